// ===== src/sdh_pkg.sv =====
// Shared types and constants for the SD card SPI host sequencer.
`timescale 1ns / 1ps
package sdh_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int WAKE_BYTES  = 15;
	localparam int GAP_BYTES   = 100;

	localparam int QDEPTH   = 8;
	localparam int QAW      = 3;
	localparam int QLEVEL_W = 4;
	localparam int QLIMIT   = QDEPTH - 4;

	localparam int APB_AW = 3;

	localparam logic REG_RETRY   = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	localparam logic [1:0] OP_REQ   = 2'd0;
	localparam logic [1:0] OP_RX    = 2'd1;
	localparam logic [1:0] OP_WDATA = 2'd2;

	localparam logic [1:0] REQ_RESET = 2'd0;
	localparam logic [1:0] REQ_INIT  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_WRITE = 2'd3;

	localparam logic [1:0] K_TX    = 2'd0;
	localparam logic [1:0] K_RDATA = 2'd1;
	localparam logic [1:0] K_WANT  = 2'd2;
	localparam logic [1:0] K_DONE  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RESET     = 3'd1;
	localparam logic [2:0] ST_INIT      = 3'd2;
	localparam logic [2:0] ST_READ_CMD  = 3'd3;
	localparam logic [2:0] ST_TOKEN_TO  = 3'd4;
	localparam logic [2:0] ST_WRITE_CMD = 3'd5;
	localparam logic [2:0] ST_REJECTED  = 3'd6;
	localparam logic [2:0] ST_BUSY_TO   = 3'd7;

	localparam logic [7:0] CMD0_CODE  = 8'h40;
	localparam logic [7:0] CMD1_CODE  = 8'h41;
	localparam logic [7:0] CMD17_CODE = 8'h51;
	localparam logic [7:0] CMD24_CODE = 8'h58;
	localparam logic [7:0] CMD0_CRC   = 8'h95;
	localparam logic [7:0] IDLE_BYTE  = 8'hFF;
	localparam logic [7:0] DATA_TOKEN = 8'hFE;
	localparam logic [7:0] R1_IDLE    = 8'h01;
	localparam logic [7:0] R1_READY   = 8'h00;
	localparam logic [4:0] DRESP_OK   = 5'h05;

	typedef enum logic [15:0] {
		PH_IDLE       = 16'h0001,
		PH_WAKE       = 16'h0002,
		PH_CMD_PRE    = 16'h0004,
		PH_CMD_BYTE   = 16'h0008,
		PH_CMD_POLL   = 16'h0010,
		PH_GAP        = 16'h0020,
		PH_TOKEN_TX   = 16'h0040,
		PH_WANT       = 16'h0080,
		PH_WDATA      = 16'h0100,
		PH_WCRC       = 16'h0200,
		PH_DRESP      = 16'h0400,
		PH_BUSY       = 16'h0800,
		PH_TOKEN_WAIT = 16'h1000,
		PH_RDATA      = 16'h2000,
		PH_RCRC       = 16'h4000,
		PH_TAIL       = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  request;
		logic [22:0] sector;
		logic [7:0]  rx_byte;
		logic [7:0]  wdata;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic       cs_active;
		logic [7:0] read_byte;
		logic [2:0] status;
		logic [7:0] response;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== src/sdh_in_if.sv =====
// Input channel: host requests, received SPI bytes and write data bytes.
`timescale 1ns / 1ps
interface sdh_in_if import sdh_pkg::*;;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [1:0]  request;
	logic [22:0] sector;
	logic [7:0]  rx_byte;
	logic [7:0]  wdata;

	modport source (output valid, op, request, sector, rx_byte, wdata, input ready);
	modport sink (input valid, op, request, sector, rx_byte, wdata, output ready);
endinterface

// ===== src/sdh_out_if.sv =====
// Output channel: transmit bytes, read data, write byte requests and completions.
`timescale 1ns / 1ps
interface sdh_out_if import sdh_pkg::*;;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] tx_byte;
	logic       cs_active;
	logic [7:0] read_byte;
	logic [2:0] status;
	logic [7:0] response;
	logic       last;

	modport source (output valid, kind, tx_byte, cs_active, read_byte, status, response, last,
		input ready);
	modport sink (input valid, kind, tx_byte, cs_active, read_byte, status, response, last,
		output ready);
endinterface

// ===== src/sdh_seq.sv =====
// Sequencer state and the per-item step logic.
`timescale 1ns / 1ps
module sdh_seq import sdh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  item_t       item_s1,
	input  logic [7:0]  retry_limit,
	input  logic [15:0] wait_timeout,
	output push_t       push
);

	phase_t      phase_q, ph_d;
	logic [9:0]  bc_q, bc_d, bc1;
	logic [7:0]  att_q, att_d, att1;
	logic [15:0] poll_q, poll_d, poll1;
	logic [22:0] sec_q, sec_d;
	logic [1:0]  act_q, act_d;
	logic [7:0]  lr_q, lr_d;
	logic [1:0]  n;
	res_t        r0, r1;
	logic [7:0]  rl;
	logic [15:0] wt;
	logic [7:0]  want;

	function automatic res_t mk_res(logic [1:0] kind, logic [7:0] txb, logic cs,
		logic [7:0] rd, logic [2:0] st, logic [7:0] resp);
		res_t r;
		r.kind      = kind;
		r.tx_byte   = txb;
		r.cs_active = cs;
		r.read_byte = rd;
		r.status    = st;
		r.response  = resp;
		r.last      = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] cmd_byte(logic [2:0] k, logic [1:0] act, logic [22:0] sec);
		logic [7:0] b;
		case (k)
			3'd0: begin
				case (act)
					REQ_RESET: b = CMD0_CODE;
					REQ_INIT:  b = CMD1_CODE;
					REQ_READ:  b = CMD17_CODE;
					default:   b = CMD24_CODE;
				endcase
			end
			3'd1: b = sec[22:15];
			3'd2: b = sec[14:7];
			3'd3: b = {sec[6:0], 1'b0};
			3'd4: b = 8'h00;
			default: b = (act == REQ_RESET) ? CMD0_CRC : IDLE_BYTE;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] fail_status(logic [1:0] act);
		logic [2:0] s;
		case (act)
			REQ_RESET: s = ST_RESET;
			REQ_INIT:  s = ST_INIT;
			REQ_READ:  s = ST_READ_CMD;
			default:   s = ST_WRITE_CMD;
		endcase
		return s;
	endfunction

	assign rl   = (retry_limit == 8'd0) ? 8'd1 : retry_limit;
	assign wt   = (wait_timeout == 16'd0) ? 16'd1 : wait_timeout;
	assign want = (act_q == REQ_RESET) ? R1_IDLE : R1_READY;
	assign bc1   = bc_q + 10'd1;
	assign poll1 = poll_q + 16'd1;
	assign att1  = att_q + 8'd1;

	always_comb begin
		ph_d   = phase_q;
		bc_d   = bc_q;
		att_d  = att_q;
		poll_d = poll_q;
		sec_d  = sec_q;
		act_d  = act_q;
		lr_d   = lr_q;
		n      = 2'd0;
		r0     = '0;
		r1     = '0;
		case (item_s1.op)
			OP_REQ: begin
				if (phase_q == PH_IDLE) begin
					act_d  = item_s1.request;
					sec_d  = (item_s1.request >= REQ_READ) ? item_s1.sector : 23'd0;
					att_d  = 8'd0;
					poll_d = 16'd0;
					bc_d   = 10'd0;
					ph_d   = (item_s1.request == REQ_RESET) ? PH_WAKE : PH_CMD_PRE;
					r0     = mk_res(K_TX, IDLE_BYTE, 1'b0, 8'h00, ST_OK, lr_q);
					n      = 2'd1;
				end
			end
			OP_WDATA: begin
				if (phase_q == PH_WANT) begin
					ph_d = PH_WDATA;
					r0   = mk_res(K_TX, item_s1.wdata, 1'b1, 8'h00, ST_OK, lr_q);
					n    = 2'd1;
				end
			end
			OP_RX: begin
				n = 2'd1;
				case (phase_q)
					PH_WAKE: begin
						bc_d = bc1;
						if (bc1 >= 10'(WAKE_BYTES)) ph_d = PH_CMD_PRE;
						r0 = mk_res(K_TX, IDLE_BYTE, 1'b0, 8'h00, ST_OK, lr_q);
					end
					PH_CMD_PRE: begin
						bc_d = 10'd0;
						ph_d = PH_CMD_BYTE;
						r0 = mk_res(K_TX, cmd_byte(3'd0, act_q, sec_q), 1'b1, 8'h00, ST_OK,
							lr_q);
					end
					PH_CMD_BYTE: begin
						bc_d = bc1;
						if (bc1 < 10'd6) begin
							r0 = mk_res(K_TX, cmd_byte(bc1[2:0], act_q, sec_q), 1'b1, 8'h00,
								ST_OK, lr_q);
						end else begin
							poll_d = 16'd0;
							ph_d   = PH_CMD_POLL;
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						end
					end
					PH_CMD_POLL: begin
						poll_d = poll1;
						lr_d   = item_s1.rx_byte;
						if (item_s1.rx_byte == IDLE_BYTE && poll1 < {8'd0, rl}) begin
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, item_s1.rx_byte);
						end else begin
							att_d = att1;
							if (item_s1.rx_byte == want) begin
								if (act_q < REQ_READ) begin
									ph_d = PH_TAIL;
									r0 = mk_res(K_TX, IDLE_BYTE, 1'b0, 8'h00, ST_OK,
										item_s1.rx_byte);
								end else begin
									poll_d = 16'd0;
									bc_d   = 10'd0;
									ph_d   = (act_q == REQ_READ) ? PH_TOKEN_WAIT : PH_GAP;
									r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK,
										item_s1.rx_byte);
								end
							end else if (att1 >= rl) begin
								ph_d = PH_IDLE;
								r0 = mk_res(K_DONE, 8'h00, 1'b0, 8'h00, fail_status(act_q),
									item_s1.rx_byte);
							end else begin
								ph_d = PH_CMD_PRE;
								r0 = mk_res(K_TX, IDLE_BYTE, 1'b0, 8'h00, ST_OK,
									item_s1.rx_byte);
							end
						end
					end
					PH_GAP: begin
						bc_d = bc1;
						if (bc1 < 10'(GAP_BYTES)) begin
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						end else begin
							ph_d = PH_TOKEN_TX;
							r0 = mk_res(K_TX, DATA_TOKEN, 1'b1, 8'h00, ST_OK, lr_q);
						end
					end
					PH_TOKEN_TX, PH_WDATA: begin
						if (phase_q == PH_TOKEN_TX || bc1 < 10'(BLOCK_BYTES)) begin
							bc_d = (phase_q == PH_TOKEN_TX) ? 10'd0 : bc1;
							ph_d = PH_WANT;
							r0 = mk_res(K_WANT, 8'h00, 1'b1, 8'h00, ST_OK, lr_q);
						end else begin
							bc_d = 10'd0;
							ph_d = PH_WCRC;
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						end
					end
					PH_WCRC: begin
						bc_d = bc1;
						if (bc1 >= 10'd2) ph_d = PH_DRESP;
						r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
					end
					PH_DRESP: begin
						lr_d = item_s1.rx_byte;
						if (item_s1.rx_byte[4:0] != DRESP_OK) begin
							ph_d = PH_IDLE;
							r0 = mk_res(K_DONE, 8'h00, 1'b0, 8'h00, ST_REJECTED, item_s1.rx_byte);
						end else begin
							poll_d = 16'd0;
							ph_d   = PH_BUSY;
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, item_s1.rx_byte);
						end
					end
					PH_BUSY: begin
						poll_d = poll1;
						if (item_s1.rx_byte == IDLE_BYTE) begin
							ph_d = PH_TAIL;
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b0, 8'h00, ST_OK, lr_q);
						end else if (poll1 >= wt) begin
							ph_d = PH_IDLE;
							r0 = mk_res(K_DONE, 8'h00, 1'b0, 8'h00, ST_BUSY_TO, lr_q);
						end else begin
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						end
					end
					PH_TOKEN_WAIT: begin
						poll_d = poll1;
						if (item_s1.rx_byte == DATA_TOKEN) begin
							bc_d = 10'd0;
							ph_d = PH_RDATA;
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						end else if (poll1 >= wt) begin
							ph_d = PH_IDLE;
							r0 = mk_res(K_DONE, 8'h00, 1'b0, 8'h00, ST_TOKEN_TO, lr_q);
						end else begin
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						end
					end
					PH_RDATA: begin
						r0 = mk_res(K_RDATA, 8'h00, 1'b1, item_s1.rx_byte, ST_OK, lr_q);
						r1 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						n  = 2'd2;
						if (bc1 >= 10'(BLOCK_BYTES)) begin
							bc_d = 10'd0;
							ph_d = PH_RCRC;
						end else begin
							bc_d = bc1;
						end
					end
					PH_RCRC: begin
						bc_d = bc1;
						if (bc1 < 10'd2) begin
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b1, 8'h00, ST_OK, lr_q);
						end else begin
							ph_d = PH_TAIL;
							r0 = mk_res(K_TX, IDLE_BYTE, 1'b0, 8'h00, ST_OK, lr_q);
						end
					end
					PH_TAIL: begin
						ph_d = PH_IDLE;
						r0 = mk_res(K_DONE, 8'h00, 1'b0, 8'h00, ST_OK, lr_q);
					end
					default: begin
						// idle or waiting for a write byte: received byte is dropped
						n = 2'd0;
					end
				endcase
			end
			default: n = 2'd0;
		endcase
		if (n == 2'd1) r0.last = 1'b1;
		if (n == 2'd2) r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bc_q    <= '0;
			att_q   <= '0;
			poll_q  <= '0;
			sec_q   <= '0;
			act_q   <= REQ_RESET;
			lr_q    <= IDLE_BYTE;
		end else if (valid_s1) begin
			phase_q <= ph_d;
			bc_q    <= bc_d;
			att_q   <= att_d;
			poll_q  <= poll_d;
			sec_q   <= sec_d;
			act_q   <= act_d;
			lr_q    <= lr_d;
		end
	end

	always_comb begin
		push    = '0;
		push.n  = valid_s1 ? n : 2'd0;
		push.r0 = r0;
		push.r1 = r1;
	end

endmodule

// ===== src/sdh_outq.sv =====
// Result queue: takes up to two results a cycle, hands out one per transfer.
`timescale 1ns / 1ps
module sdh_outq import sdh_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  push_t               push,
	output logic [QLEVEL_W-1:0] level,
	sdh_out_if.source           out_ch
);

	res_t                mem [QDEPTH];
	logic [QAW-1:0]      wp_q, rp_q;
	logic [QLEVEL_W-1:0] cnt_q;
	logic                pop;
	res_t                head;

	assign head  = mem[rp_q];
	assign pop   = out_ch.valid & out_ch.ready;
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem[wp_q] <= push.r0;
		if (push.n == 2'd2) mem[wp_q + QAW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QAW'(push.n);
			rp_q  <= rp_q + QAW'(pop);
			cnt_q <= cnt_q + QLEVEL_W'(push.n) - QLEVEL_W'(pop);
		end
	end

	assign out_ch.valid     = (cnt_q != '0);
	assign out_ch.kind      = head.kind;
	assign out_ch.tx_byte   = head.tx_byte;
	assign out_ch.cs_active = head.cs_active;
	assign out_ch.read_byte = head.read_byte;
	assign out_ch.status    = head.status;
	assign out_ch.response  = head.response;
	assign out_ch.last      = head.last;

endmodule

// ===== src/sd_card_spi_block_host.sv =====
// Top level of the SD card SPI-mode block host sequencer.
//
// Usage: the in_ch channel carries host requests (reset, init, read block,
// write block), the byte received on MISO for each transmit result, and the
// write data bytes asked for by "want write byte" results. The out_ch channel
// carries transmit bytes with the chip-select level, read data bytes, write
// byte requests and one completion per request taken while idle (a request
// that comes while busy is dropped), last marking the final result of an item.
// retry_limit and wait_timeout are written over the APB port (byte addresses
// 0 and 4); the user must write them only while the block is idle, the block
// itself does not enforce it. An item is registered at acceptance and its
// results are then written into the result queue, whose head drives out_ch.
// Throughput is one item per cycle; a received read data
// byte gives two results, so there the output port's one transfer per cycle
// sets the rate. in_ch.ready drops when the eight-entry result queue holds more
// than four results, so a stalled receiver backs up into the input without
// loss. Reset clears the sequencer to idle, empties the queue and loads
// retry_limit 200 and wait_timeout 65535.
`timescale 1ns / 1ps
module sd_card_spi_block_host import sdh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sdh_in_if.sink            in_ch,
	sdh_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic                valid_s1;
	item_t               item_s1;
	logic [7:0]          retry_limit_q;
	logic [15:0]         wait_timeout_q;
	push_t               push;
	logic [QLEVEL_W-1:0] q_level;
	logic                cfg_wr;

	assign in_ch.ready = (q_level <= QLEVEL_W'(QLIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_ch.valid & in_ch.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid & in_ch.ready) begin
			item_s1.op      <= in_ch.op;
			item_s1.request <= in_ch.request;
			item_s1.sector  <= in_ch.sector;
			item_s1.rx_byte <= in_ch.rx_byte;
			item_s1.wdata   <= in_ch.wdata;
		end
	end

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q  <= 8'd200;
			wait_timeout_q <= 16'hFFFF;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_RETRY) retry_limit_q <= pwdata[7:0];
			if (paddr[2] == REG_TIMEOUT) wait_timeout_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_RETRY) ? {24'd0, retry_limit_q} : {16'd0, wait_timeout_q};

	sdh_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.retry_limit  (retry_limit_q),
		.wait_timeout (wait_timeout_q),
		.push         (push)
	);

	sdh_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.level  (q_level),
		.out_ch (out_ch)
	);

	a_room_for_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> q_level <= QLEVEL_W'(QDEPTH - 2))
		else $error("result queue lacks room for registered item");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QLEVEL_W'(QDEPTH))
		else $error("result queue overflow");

	a_pair_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r0.kind == K_RDATA && push.r1.kind == K_TX && push.r1.last)
		else $error("two results from an item other than a read data byte");

endmodule
